[rtl/magnifier_lens_vertex_warp_unit_macros.svh]
// assertion helpers for the file that checks its own logic
`ifndef MAGNIFIER_LENS_VERTEX_WARP_UNIT_MACROS_SVH
`define MAGNIFIER_LENS_VERTEX_WARP_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MLW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mlw assertion failed");
// next-cycle implication
`define MLW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mlw assertion failed");
`else
`define MLW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MLW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/mlw_pkg.sv]
`timescale 1ns / 1ps

package mlw_pkg;

    // mesh geometry
    localparam int GRID_POINTS = 16;
    localparam int GRID_DEN    = (GRID_POINTS > 1) ? GRID_POINTS - 1 : 1;
    localparam int GRID_STEP   = 65536 / GRID_DEN;
    localparam int HALF_SPAN   = 32768;
    localparam int IDX_W       = 8;
    localparam int TEX_W       = 17;

    // lens constants
    localparam int LENS_OUTER_SQ = 8028;
    localparam int LENS_INNER_SQ = 2621;
    localparam int LENS_BAND     = LENS_OUTER_SQ - LENS_INNER_SQ;
    localparam int UNITY_ZOOM    = 4096;
    localparam int ZOOM_SH       = 12;
    localparam int ASPECT_SH     = 16;
    localparam int DIST_SH       = 8;
    localparam int Z_INSIDE      = 128;

    // register widths
    localparam int COORD_W    = 32;
    localparam int ZOOM_W     = 16;
    localparam int ASP_W      = 17;
    localparam int Z_W        = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // datapath widths
    localparam int POS_W    = $clog2(((1 << IDX_W) - 1) * GRID_STEP + 1) + 1;
    localparam int PROD_A_W = POS_W + ASP_W + 1;
    localparam int SC_W     = POS_W + 1;
    localparam int D_W      = ((SC_W > COORD_W) ? SC_W : COORD_W) + 1;
    localparam int Q_W      = D_W - DIST_SH;
    localparam int SQ_W     = 2 * Q_W - 1;
    localparam int DIST_W   = SQ_W + 1;
    localparam int BAND_W   = $clog2(LENS_BAND);
    localparam int ZD_W     = ZOOM_W + 1;
    localparam int MAG_W    = ZD_W - 1 + BAND_W;
    localparam int RECIP_SH = MAG_W + BAND_W;
    localparam int RECIP_W  = MAG_W + 1;
    localparam int QUOT_W   = MAG_W - BAND_W + 1;
    localparam int ZE_W     = ZOOM_W + 2;
    localparam int ZP_W     = D_W + ZE_W;
    localparam int NX_W     = ZP_W - ZOOM_SH + 1;

    // exact reciprocal of the easing band for dividends below 2^MAG_W
    localparam longint RECIP_K =
        ((longint'(1) << RECIP_SH) + longint'(LENS_BAND) - 1) / longint'(LENS_BAND);
    localparam logic [RECIP_W-1:0] RECIP_KV = RECIP_W'(RECIP_K);

    // texture coordinate table, one entry per index value
    typedef logic [TEX_W-1:0] t_tex_lut [0:(1 << IDX_W) - 1];

    function automatic t_tex_lut f_tex_lut();
        t_tex_lut lut;
        for (int i = 0; i < (1 << IDX_W); i++) begin
            lut[i] = TEX_W'((longint'(i) * 65536) / GRID_DEN);
        end
        return lut;
    endfunction

    localparam t_tex_lut TEX_LUT = f_tex_lut();

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FINGER_X     = 3'd0,
        CFG_FINGER_Y     = 3'd1,
        CFG_ZOOM_FACTOR  = 3'd2,
        CFG_ASPECT_SCALE = 3'd3,
        CFG_ASPECT_AXIS  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] finger_x;
        logic signed [COORD_W-1:0] finger_y;
        logic [ZOOM_W-1:0]         zoom_factor;
        logic [ASP_W-1:0]          aspect_scale;
        logic                      aspect_axis;
    } t_cfg;

    // fields that ride along the whole pipe
    typedef struct packed {
        logic signed [SC_W-1:0] pos_x;
        logic signed [SC_W-1:0] pos_y;
        logic signed [D_W-1:0]  dx;
        logic signed [D_W-1:0]  dy;
        logic [TEX_W-1:0]       tex_u;
        logic [TEX_W-1:0]       tex_v;
    } t_carry;

    typedef struct packed {
        t_carry                c;
        logic signed [Q_W-1:0] qx;
        logic signed [Q_W-1:0] qy;
    } t_place;

    typedef struct packed {
        t_carry                 c;
        logic                   in_lens;
        logic signed [ZE_W-1:0] zoom_eff;
    } t_zoom;

endpackage

[rtl/mlw_in_if.sv]
`timescale 1ns / 1ps

interface mlw_in_if;
    logic                       valid;
    logic                       ready;
    logic [mlw_pkg::IDX_W-1:0]  grid_col;
    logic [mlw_pkg::IDX_W-1:0]  grid_row;

    modport source (output valid, output grid_col, output grid_row, input ready);
    modport sink   (input valid, input grid_col, input grid_row, output ready);
endinterface

[rtl/mlw_out_if.sv]
`timescale 1ns / 1ps

interface mlw_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [mlw_pkg::COORD_W-1:0] vert_x;
    logic signed [mlw_pkg::COORD_W-1:0] vert_y;
    logic [mlw_pkg::Z_W-1:0]            vert_z;
    logic [mlw_pkg::TEX_W-1:0]          tex_u;
    logic [mlw_pkg::TEX_W-1:0]          tex_v;

    modport source (output valid, output vert_x, output vert_y, output vert_z,
                    output tex_u, output tex_v, input ready);
    modport sink   (input valid, input vert_x, input vert_y, input vert_z,
                    input tex_u, input tex_v, output ready);
endinterface

[rtl/mlw_cfg.sv]
`timescale 1ns / 1ps

module mlw_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mlw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mlw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output mlw_pkg::t_cfg                   o_cfg
);

    mlw_pkg::t_cfg r_cfg;
    mlw_pkg::t_cfg n_cfg;

    // register decode, unknown indexes leave everything alone
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (mlw_pkg::t_cfg_idx'(i_cfg_idx))
                mlw_pkg::CFG_FINGER_X:     n_cfg.finger_x = $signed(i_cfg_data);
                mlw_pkg::CFG_FINGER_Y:     n_cfg.finger_y = $signed(i_cfg_data);
                mlw_pkg::CFG_ZOOM_FACTOR:
                    n_cfg.zoom_factor = i_cfg_data[mlw_pkg::ZOOM_W-1:0];
                mlw_pkg::CFG_ASPECT_SCALE:
                    n_cfg.aspect_scale = i_cfg_data[mlw_pkg::ASP_W-1:0];
                mlw_pkg::CFG_ASPECT_AXIS:  n_cfg.aspect_axis = i_cfg_data[0];
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.finger_x     <= '0;
            r_cfg.finger_y     <= '0;
            r_cfg.zoom_factor  <= mlw_pkg::ZOOM_W'(mlw_pkg::UNITY_ZOOM);
            r_cfg.aspect_scale <= mlw_pkg::ASP_W'(65536);
            r_cfg.aspect_axis  <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/mlw_place.sv]
`timescale 1ns / 1ps

module mlw_place (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mlw_pkg::t_cfg               i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [mlw_pkg::IDX_W-1:0]   i_grid_col,
    input  logic [mlw_pkg::IDX_W-1:0]   i_grid_row,
    output logic                        o_valid,
    input  logic                        i_ready,
    output mlw_pkg::t_place             o_data
);

    localparam int POS_W    = mlw_pkg::POS_W;
    localparam int PROD_A_W = mlw_pkg::PROD_A_W;
    localparam int SC_W     = mlw_pkg::SC_W;
    localparam int D_W      = mlw_pkg::D_W;
    localparam int Q_W      = mlw_pkg::Q_W;
    localparam logic signed [POS_W-1:0]    HALF    = POS_W'(mlw_pkg::HALF_SPAN);
    localparam logic signed [PROD_A_W-1:0] ASP_RND =
        PROD_A_W'((1 << mlw_pkg::ASPECT_SH) - 1);
    localparam logic signed [D_W-1:0]      Q_RND   = D_W'((1 << mlw_pkg::DIST_SH) - 1);

    // stage 1: mesh placement and aspect product
    logic                              r_s1_v;
    logic signed [PROD_A_W-1:0]        r_s1_prod;
    logic signed [POS_W-1:0]           r_s1_other;
    logic [mlw_pkg::TEX_W-1:0]         r_s1_tex_u;
    logic [mlw_pkg::TEX_W-1:0]         r_s1_tex_v;
    // stage 2: finger offsets
    logic                              r_s2_v;
    mlw_pkg::t_place                   r_s2_data;

    logic                              w_rdy1;
    logic                              w_rdy2;
    logic signed [POS_W-1:0]           w_x0;
    logic signed [POS_W-1:0]           w_y0;
    logic signed [POS_W-1:0]           w_sel;
    logic signed [POS_W-1:0]           w_other;
    logic signed [PROD_A_W-1:0]        w_prod;
    logic signed [PROD_A_W-1:0]        w_adj;
    logic signed [SC_W-1:0]            w_scaled;
    logic signed [SC_W-1:0]            w_other_ext;
    logic signed [SC_W-1:0]            w_px;
    logic signed [SC_W-1:0]            w_py;
    logic signed [D_W-1:0]             w_dx;
    logic signed [D_W-1:0]             w_dy;
    logic signed [D_W-1:0]             w_dx_adj;
    logic signed [D_W-1:0]             w_dy_adj;

    // stall chain, a stage takes a beat when it is empty or drains
    assign w_rdy2  = !r_s2_v || i_ready;
    assign w_rdy1  = !r_s1_v || w_rdy2;
    assign o_ready = w_rdy1;

    // place the grid point and pick the axis that gets the aspect factor
    always_comb begin
        w_x0 = $signed({1'b0, (POS_W-1)'(i_grid_col * mlw_pkg::GRID_STEP)}) - HALF;
        w_y0 = HALF - $signed({1'b0, (POS_W-1)'(i_grid_row * mlw_pkg::GRID_STEP)});
        w_sel   = i_cfg.aspect_axis ? w_y0 : w_x0;
        w_other = i_cfg.aspect_axis ? w_x0 : w_y0;
        w_prod  = w_sel * $signed({1'b0, i_cfg.aspect_scale});
    end

    // aspect scale truncated toward zero, then offsets and their coarse quotients
    always_comb begin
        w_adj       = r_s1_prod + (r_s1_prod[PROD_A_W-1] ? ASP_RND : '0);
        w_scaled    = SC_W'(w_adj >>> mlw_pkg::ASPECT_SH);
        w_other_ext = SC_W'(r_s1_other);
        w_px        = i_cfg.aspect_axis ? w_other_ext : w_scaled;
        w_py        = i_cfg.aspect_axis ? w_scaled : w_other_ext;
        w_dx        = D_W'($signed(i_cfg.finger_x)) - D_W'(w_px);
        w_dy        = D_W'($signed(i_cfg.finger_y)) - D_W'(w_py);
        w_dx_adj    = w_dx + (w_dx[D_W-1] ? Q_RND : '0);
        w_dy_adj    = w_dy + (w_dy[D_W-1] ? Q_RND : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_s1_v <= i_valid;
            end
            if (w_rdy2) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_prod  <= w_prod;
            r_s1_other <= w_other;
            r_s1_tex_u <= mlw_pkg::TEX_LUT[i_grid_col];
            r_s1_tex_v <= mlw_pkg::TEX_LUT[i_grid_row];
        end
        if (w_rdy2) begin
            r_s2_data.c.pos_x <= w_px;
            r_s2_data.c.pos_y <= w_py;
            r_s2_data.c.dx    <= w_dx;
            r_s2_data.c.dy    <= w_dy;
            r_s2_data.c.tex_u <= r_s1_tex_u;
            r_s2_data.c.tex_v <= r_s1_tex_v;
            r_s2_data.qx      <= Q_W'(w_dx_adj >>> mlw_pkg::DIST_SH);
            r_s2_data.qy      <= Q_W'(w_dy_adj >>> mlw_pkg::DIST_SH);
        end
    end

    assign o_valid = r_s2_v;
    assign o_data  = r_s2_data;

endmodule

[rtl/mlw_zoom.sv]
`timescale 1ns / 1ps

module mlw_zoom (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mlw_pkg::t_cfg   i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  mlw_pkg::t_place i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output mlw_pkg::t_zoom  o_data
);

    localparam int Q_W    = mlw_pkg::Q_W;
    localparam int SQ_W   = mlw_pkg::SQ_W;
    localparam int DIST_W = mlw_pkg::DIST_W;
    localparam int BAND_W = mlw_pkg::BAND_W;
    localparam int ZD_W   = mlw_pkg::ZD_W;
    localparam int MAG_W  = mlw_pkg::MAG_W;
    localparam int BP_W   = ZD_W + BAND_W + 1;
    localparam int RP_W   = MAG_W + mlw_pkg::RECIP_W;
    localparam int QUOT_W = mlw_pkg::QUOT_W;
    localparam int ZE_W   = mlw_pkg::ZE_W;

    // stage 3: squared quotients
    logic                      r_s3_v;
    mlw_pkg::t_carry           r_s3_c;
    logic [SQ_W-1:0]           r_s3_sqx;
    logic [SQ_W-1:0]           r_s3_sqy;
    // stage 4: distance and lens flags
    logic                      r_s4_v;
    mlw_pkg::t_carry           r_s4_c;
    logic                      r_s4_inside;
    logic                      r_s4_ease;
    logic [BAND_W-1:0]         r_s4_diff;
    // stage 5: easing product magnitude
    logic                      r_s5_v;
    mlw_pkg::t_carry           r_s5_c;
    logic                      r_s5_inside;
    logic                      r_s5_ease;
    logic                      r_s5_neg;
    logic [MAG_W-1:0]          r_s5_mag;
    // stage 6: division by the band width
    logic                      r_s6_v;
    mlw_pkg::t_carry           r_s6_c;
    logic                      r_s6_inside;
    logic                      r_s6_ease;
    logic                      r_s6_neg;
    logic [QUOT_W-1:0]         r_s6_quot;
    // stage 7: effective zoom
    logic                      r_s7_v;
    mlw_pkg::t_zoom            r_s7_data;

    logic                      w_rdy3;
    logic                      w_rdy4;
    logic                      w_rdy5;
    logic                      w_rdy6;
    logic                      w_rdy7;
    logic signed [2*Q_W-1:0]   w_sqx;
    logic signed [2*Q_W-1:0]   w_sqy;
    logic [DIST_W-1:0]         w_dist;
    logic signed [ZD_W-1:0]    w_zd;
    logic signed [BP_W-1:0]    w_band;
    logic signed [BP_W-1:0]    w_band_abs;
    logic [RP_W-1:0]           w_rprod;
    logic signed [ZE_W-1:0]    w_quot_s;
    logic signed [ZE_W-1:0]    w_ze;

    // stall chain
    assign w_rdy7  = !r_s7_v || i_ready;
    assign w_rdy6  = !r_s6_v || w_rdy7;
    assign w_rdy5  = !r_s5_v || w_rdy6;
    assign w_rdy4  = !r_s4_v || w_rdy5;
    assign w_rdy3  = !r_s3_v || w_rdy4;
    assign o_ready = w_rdy3;

    // squares of the coarse offsets
    always_comb begin
        w_sqx = $signed(i_data.qx) * $signed(i_data.qx);
        w_sqy = $signed(i_data.qy) * $signed(i_data.qy);
    end

    // distance against the lens radii; only the low bits of the margin matter
    always_comb begin
        w_dist = DIST_W'(r_s3_sqx) + DIST_W'(r_s3_sqy);
    end

    // signed zoom excess times the outer margin, kept as sign and magnitude
    always_comb begin
        w_zd       = $signed({1'b0, i_cfg.zoom_factor}) - ZD_W'(mlw_pkg::UNITY_ZOOM);
        w_band     = w_zd * $signed({1'b0, r_s4_diff});
        w_band_abs = w_band[BP_W-1] ? -w_band : w_band;
    end

    // reciprocal multiply gives the exact truncated quotient
    always_comb begin
        w_rprod = RP_W'(r_s5_mag) * RP_W'(mlw_pkg::RECIP_KV);
    end

    // eased zoom beyond the inner radius, core zoom otherwise
    always_comb begin
        w_quot_s = r_s6_neg ? -ZE_W'(r_s6_quot) : ZE_W'(r_s6_quot);
        w_ze     = r_s6_ease ? ZE_W'(mlw_pkg::UNITY_ZOOM) + w_quot_s
                             : ZE_W'({1'b0, i_cfg.zoom_factor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
            r_s7_v <= 1'b0;
        end else begin
            if (w_rdy3) begin
                r_s3_v <= i_valid;
            end
            if (w_rdy4) begin
                r_s4_v <= r_s3_v;
            end
            if (w_rdy5) begin
                r_s5_v <= r_s4_v;
            end
            if (w_rdy6) begin
                r_s6_v <= r_s5_v;
            end
            if (w_rdy7) begin
                r_s7_v <= r_s6_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_s3_c   <= i_data.c;
            r_s3_sqx <= w_sqx[SQ_W-1:0];
            r_s3_sqy <= w_sqy[SQ_W-1:0];
        end
        if (w_rdy4) begin
            r_s4_c      <= r_s3_c;
            r_s4_inside <= w_dist < DIST_W'(mlw_pkg::LENS_OUTER_SQ);
            r_s4_ease   <= w_dist > DIST_W'(mlw_pkg::LENS_INNER_SQ);
            r_s4_diff   <= BAND_W'(mlw_pkg::LENS_OUTER_SQ) - w_dist[BAND_W-1:0];
        end
        if (w_rdy5) begin
            r_s5_c      <= r_s4_c;
            r_s5_inside <= r_s4_inside;
            r_s5_ease   <= r_s4_ease;
            r_s5_neg    <= w_band[BP_W-1];
            r_s5_mag    <= w_band_abs[MAG_W-1:0];
        end
        if (w_rdy6) begin
            r_s6_c      <= r_s5_c;
            r_s6_inside <= r_s5_inside;
            r_s6_ease   <= r_s5_ease;
            r_s6_neg    <= r_s5_neg;
            r_s6_quot   <= w_rprod[mlw_pkg::RECIP_SH +: QUOT_W];
        end
        if (w_rdy7) begin
            r_s7_data.c        <= r_s6_c;
            r_s7_data.in_lens  <= r_s6_inside;
            r_s7_data.zoom_eff <= w_ze;
        end
    end

    assign o_valid = r_s7_v;
    assign o_data  = r_s7_data;

endmodule

[rtl/mlw_apply.sv]
`timescale 1ns / 1ps

module mlw_apply (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mlw_pkg::t_cfg                       i_cfg,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  mlw_pkg::t_zoom                      i_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [mlw_pkg::COORD_W-1:0]  o_vert_x,
    output logic signed [mlw_pkg::COORD_W-1:0]  o_vert_y,
    output logic [mlw_pkg::Z_W-1:0]             o_vert_z,
    output logic [mlw_pkg::TEX_W-1:0]           o_tex_u,
    output logic [mlw_pkg::TEX_W-1:0]           o_tex_v
);

    localparam int ZP_W    = mlw_pkg::ZP_W;
    localparam int NX_W    = mlw_pkg::NX_W;
    localparam int COORD_W = mlw_pkg::COORD_W;
    localparam int SC_W    = mlw_pkg::SC_W;
    localparam logic signed [ZP_W-1:0] Z_RND  = ZP_W'((1 << mlw_pkg::ZOOM_SH) - 1);
    localparam logic signed [NX_W-1:0] SAT_HI = NX_W'(32'sh7FFF_FFFF);
    localparam logic signed [NX_W-1:0] SAT_LO = NX_W'(32'sh8000_0000);

    // stage 8: zoomed offsets
    logic                           r_s8_v;
    logic signed [ZP_W-1:0]         r_s8_px;
    logic signed [ZP_W-1:0]         r_s8_py;
    logic signed [SC_W-1:0]         r_s8_pos_x;
    logic signed [SC_W-1:0]         r_s8_pos_y;
    logic                           r_s8_inside;
    logic [mlw_pkg::TEX_W-1:0]      r_s8_tex_u;
    logic [mlw_pkg::TEX_W-1:0]      r_s8_tex_v;
    // stage 9: output beat
    logic                           r_s9_v;
    logic signed [COORD_W-1:0]      r_s9_x;
    logic signed [COORD_W-1:0]      r_s9_y;
    logic [mlw_pkg::Z_W-1:0]        r_s9_z;
    logic [mlw_pkg::TEX_W-1:0]      r_s9_tex_u;
    logic [mlw_pkg::TEX_W-1:0]      r_s9_tex_v;

    logic                           w_rdy8;
    logic                           w_rdy9;
    logic signed [ZP_W-1:0]         w_px;
    logic signed [ZP_W-1:0]         w_py;
    logic signed [ZP_W-1:0]         w_px_adj;
    logic signed [ZP_W-1:0]         w_py_adj;
    logic signed [NX_W-1:0]         w_nx;
    logic signed [NX_W-1:0]         w_ny;
    logic signed [NX_W-1:0]         w_vx;
    logic signed [NX_W-1:0]         w_vy;
    logic signed [COORD_W-1:0]      w_sx;
    logic signed [COORD_W-1:0]      w_sy;

    // stall chain
    assign w_rdy9  = !r_s9_v || i_ready;
    assign w_rdy8  = !r_s8_v || w_rdy9;
    assign o_ready = w_rdy8;

    // offset times effective zoom
    always_comb begin
        w_px = $signed(i_data.c.dx) * $signed(i_data.zoom_eff);
        w_py = $signed(i_data.c.dy) * $signed(i_data.zoom_eff);
    end

    // drop the zoom fraction toward zero, pull back from the finger, saturate
    always_comb begin
        w_px_adj = r_s8_px + (r_s8_px[ZP_W-1] ? Z_RND : '0);
        w_py_adj = r_s8_py + (r_s8_py[ZP_W-1] ? Z_RND : '0);
        w_nx = NX_W'($signed(i_cfg.finger_x)) - NX_W'(w_px_adj >>> mlw_pkg::ZOOM_SH);
        w_ny = NX_W'($signed(i_cfg.finger_y)) - NX_W'(w_py_adj >>> mlw_pkg::ZOOM_SH);
        w_vx = r_s8_inside ? w_nx : NX_W'(r_s8_pos_x);
        w_vy = r_s8_inside ? w_ny : NX_W'(r_s8_pos_y);
        if (w_vx > SAT_HI) begin
            w_sx = COORD_W'(SAT_HI);
        end else if (w_vx < SAT_LO) begin
            w_sx = COORD_W'(SAT_LO);
        end else begin
            w_sx = COORD_W'(w_vx);
        end
        if (w_vy > SAT_HI) begin
            w_sy = COORD_W'(SAT_HI);
        end else if (w_vy < SAT_LO) begin
            w_sy = COORD_W'(SAT_LO);
        end else begin
            w_sy = COORD_W'(w_vy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_v <= 1'b0;
            r_s9_v <= 1'b0;
        end else begin
            if (w_rdy8) begin
                r_s8_v <= i_valid;
            end
            if (w_rdy9) begin
                r_s9_v <= r_s8_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy8) begin
            r_s8_px     <= w_px;
            r_s8_py     <= w_py;
            r_s8_pos_x  <= i_data.c.pos_x;
            r_s8_pos_y  <= i_data.c.pos_y;
            r_s8_inside <= i_data.in_lens;
            r_s8_tex_u  <= i_data.c.tex_u;
            r_s8_tex_v  <= i_data.c.tex_v;
        end
        if (w_rdy9) begin
            r_s9_x     <= w_sx;
            r_s9_y     <= w_sy;
            r_s9_z     <= r_s8_inside ? mlw_pkg::Z_W'(mlw_pkg::Z_INSIDE) : '0;
            r_s9_tex_u <= r_s8_tex_u;
            r_s9_tex_v <= r_s8_tex_v;
        end
    end

    assign o_valid  = r_s9_v;
    assign o_vert_x = r_s9_x;
    assign o_vert_y = r_s9_y;
    assign o_vert_z = r_s9_z;
    assign o_tex_u  = r_s9_tex_u;
    assign o_tex_v  = r_s9_tex_v;

endmodule

[rtl/magnifier_lens_vertex_warp_unit.sv]
// throughput: one beat per cycle unless o_res.ready holds the pipe; nine register stages
// stalls: each stage holds its beat and takes a new one when empty, so bubbles close up
// reset: synchronous, active low; clears all stage valid bits and loads register defaults
// (finger 0, zoom 1.0, aspect 1.0 on x); no clearing pass, ready from the first cycle
`timescale 1ns / 1ps

`include "magnifier_lens_vertex_warp_unit_macros.svh"

module magnifier_lens_vertex_warp_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mlw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mlw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    mlw_in_if.sink                          i_in,
    mlw_out_if.source                       o_res
);

    mlw_pkg::t_cfg   w_cfg;
    logic            w_place_valid;
    logic            w_place_ready;
    mlw_pkg::t_place w_place_data;
    logic            w_zoom_valid;
    logic            w_zoom_ready;
    mlw_pkg::t_zoom  w_zoom_data;

    // register file
    mlw_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // mesh placement, aspect and finger offsets
    mlw_place u_place (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (i_in.valid),
        .o_ready    (i_in.ready),
        .i_grid_col (i_in.grid_col),
        .i_grid_row (i_in.grid_row),
        .o_valid    (w_place_valid),
        .i_ready    (w_place_ready),
        .o_data     (w_place_data)
    );

    // distance test and zoom easing
    mlw_zoom u_zoom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_place_valid),
        .o_ready (w_place_ready),
        .i_data  (w_place_data),
        .o_valid (w_zoom_valid),
        .i_ready (w_zoom_ready),
        .o_data  (w_zoom_data)
    );

    // magnify, saturate and present the result beat
    mlw_apply u_apply (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (w_zoom_valid),
        .o_ready  (w_zoom_ready),
        .i_data   (w_zoom_data),
        .o_valid  (o_res.valid),
        .i_ready  (o_res.ready),
        .o_vert_x (o_res.vert_x),
        .o_vert_y (o_res.vert_y),
        .o_vert_z (o_res.vert_z),
        .o_tex_u  (o_res.tex_u),
        .o_tex_v  (o_res.tex_v)
    );

    // an empty output stage means the whole pipe can take a beat
    `MLW_ASSERT_IMP(a_ready_when_drained, i_clk, i_rst_n, !o_res.valid, i_in.ready)
    // z only ever takes its two lens values
    `MLW_ASSERT_IMP(a_z_code, i_clk, i_rst_n, o_res.valid, (o_res.vert_z == '0) || (o_res.vert_z == mlw_pkg::Z_W'(mlw_pkg::Z_INSIDE)))
    // a zoom write lands in the register file
    `MLW_ASSERT_NEXT(a_zoom_write, i_clk, i_rst_n, i_cfg_we && (i_cfg_idx == mlw_pkg::CFG_ZOOM_FACTOR), w_cfg.zoom_factor == $past(i_cfg_data[mlw_pkg::ZOOM_W-1:0]))

endmodule
